### sv/blw_pkg.sv
// ----------------------------------------------------------------------------
// blw_pkg
// Shared types and constants for the line walker: coordinate and error
// widths, opcodes and the command word that the front passes to the back.
// ----------------------------------------------------------------------------
package blw_pkg;

  localparam int COORD_BITS = 12;
  localparam int ERR_BITS   = COORD_BITS + 3;
  localparam int QDEPTH     = 4;
  localparam int QPTR_BITS  = $clog2(QDEPTH);

  localparam logic OP_START = 1'b0;
  localparam logic OP_STEP  = 1'b1;

  typedef logic [COORD_BITS-1:0]      coord_t;
  typedef logic signed [ERR_BITS-1:0] err_t;

  // classified item, ready for the walker
  typedef struct packed {
    logic   is_step;
    coord_t x0;
    coord_t y0;
    coord_t major;
    coord_t minor;
    logic   x_major;
    logic   x_neg;
    logic   y_neg;
  } cmd_t;

endpackage

### sv/blw_if.sv
// ----------------------------------------------------------------------------
// blw_in_if / blw_out_if
// Valid/ready channels of the line walker: endpoint and step beats in,
// pixel beats out.
// ----------------------------------------------------------------------------
interface blw_in_if;
  logic           valid;
  logic           ready;
  logic           op;
  blw_pkg::coord_t x_start;
  blw_pkg::coord_t y_start;
  blw_pkg::coord_t x_end;
  blw_pkg::coord_t y_end;

  modport source (output valid, op, x_start, y_start, x_end, y_end, input ready);
  modport sink   (input valid, op, x_start, y_start, x_end, y_end, output ready);
endinterface

interface blw_out_if;
  logic           valid;
  logic           ready;
  blw_pkg::coord_t px;
  blw_pkg::coord_t py;
  logic           last;

  modport source (output valid, px, py, last, input ready);
  modport sink   (input valid, px, py, last, output ready);
endinterface

### sv/blw_front.sv
// ----------------------------------------------------------------------------
// blw_front
// Classifies each input beat: step requests pass through, start beats get
// their deltas, step directions and major axis worked out.
// ----------------------------------------------------------------------------
module blw_front (
  input  logic            op,
  input  blw_pkg::coord_t x_start,
  input  blw_pkg::coord_t y_start,
  input  blw_pkg::coord_t x_end,
  input  blw_pkg::coord_t y_end,
  output blw_pkg::cmd_t   cmd
);

  logic            x_neg;
  logic            y_neg;
  blw_pkg::coord_t dx;
  blw_pkg::coord_t dy;
  logic            x_major;

  always_comb begin
    x_neg   = x_end < x_start;
    y_neg   = y_end < y_start;
    dx      = x_neg ? (x_start - x_end) : (x_end - x_start);
    dy      = y_neg ? (y_start - y_end) : (y_end - y_start);
    // ties go to y
    x_major = dx > dy;

    cmd.is_step = (op == blw_pkg::OP_STEP);
    cmd.x0      = x_start;
    cmd.y0      = y_start;
    cmd.major   = x_major ? dx : dy;
    cmd.minor   = x_major ? dy : dx;
    cmd.x_major = x_major;
    cmd.x_neg   = x_neg;
    cmd.y_neg   = y_neg;
  end

endmodule

### sv/blw_fifo.sv
// ----------------------------------------------------------------------------
// blw_fifo
// Short command queue between front and back; push and pop may share a cycle.
// ----------------------------------------------------------------------------
module blw_fifo (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          push,
  input  blw_pkg::cmd_t push_data,
  input  logic          pop,
  output logic          full,
  output logic          empty,
  output blw_pkg::cmd_t head
);

  blw_pkg::cmd_t                   mem [blw_pkg::QDEPTH];
  logic [blw_pkg::QPTR_BITS-1:0]   wr_ptr_r, wr_ptr_nxt;
  logic [blw_pkg::QPTR_BITS-1:0]   rd_ptr_r, rd_ptr_nxt;
  logic [blw_pkg::QPTR_BITS:0]     cnt_r, cnt_nxt;
  logic                            do_push;
  logic                            do_pop;

  assign full    = (cnt_r == (blw_pkg::QPTR_BITS+1)'(blw_pkg::QDEPTH));
  assign empty   = (cnt_r == '0);
  assign head    = mem[rd_ptr_r];
  assign do_push = push && !full;
  assign do_pop  = pop && !empty;

  always_comb begin
    wr_ptr_nxt = do_push ? wr_ptr_r + 1'b1 : wr_ptr_r;
    rd_ptr_nxt = do_pop  ? rd_ptr_r + 1'b1 : rd_ptr_r;
    cnt_nxt    = cnt_r;
    if (do_push && !do_pop) begin
      cnt_nxt = cnt_r + 1'b1;
    end else if (do_pop && !do_push) begin
      cnt_nxt = cnt_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      cnt_r    <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      mem[wr_ptr_r] <= push_data;
    end
  end

endmodule

### sv/blw_back.sv
// ----------------------------------------------------------------------------
// blw_back
// Walker: holds the line state, steps one pixel per step command and drives
// the registered pixel output.
// ----------------------------------------------------------------------------
module blw_back (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              cmd_valid,
  input  blw_pkg::cmd_t     cmd,
  output logic              cmd_pop,
  blw_out_if.source         out_chan
);

  localparam int EXT = blw_pkg::ERR_BITS - blw_pkg::COORD_BITS;

  blw_pkg::coord_t cur_x_r, cur_x_nxt;
  blw_pkg::coord_t cur_y_r, cur_y_nxt;
  blw_pkg::err_t   err_r, err_nxt;
  blw_pkg::err_t   inc_pos_r, inc_pos_nxt;   // 2*minor
  blw_pkg::err_t   inc_neg_r, inc_neg_nxt;   // 2*(minor-major)
  blw_pkg::coord_t steps_r, steps_nxt;
  logic            x_major_r, x_major_nxt;
  logic            x_neg_r, x_neg_nxt;
  logic            y_neg_r, y_neg_nxt;

  logic            out_valid_r, out_valid_nxt;
  blw_pkg::coord_t px_r, px_nxt;
  blw_pkg::coord_t py_r, py_nxt;
  logic            last_r, last_nxt;

  logic            can_take;
  blw_pkg::err_t   major_e;
  blw_pkg::err_t   minor2_e;
  logic            step_minor;
  blw_pkg::coord_t x_walk;
  blw_pkg::coord_t y_walk;

  assign out_chan.valid = out_valid_r;
  assign out_chan.px    = px_r;
  assign out_chan.py    = py_r;
  assign out_chan.last  = last_r;

  // output slot is free or drains this cycle
  assign can_take = !out_valid_r || out_chan.ready;
  assign cmd_pop  = cmd_valid && can_take;

  always_comb begin
    major_e    = blw_pkg::err_t'({{EXT{1'b0}}, cmd.major});
    minor2_e   = blw_pkg::err_t'({{(EXT-1){1'b0}}, cmd.minor, 1'b0});
    step_minor = !err_r[blw_pkg::ERR_BITS-1];
    x_walk     = x_neg_r ? cur_x_r - blw_pkg::coord_t'(1) : cur_x_r + blw_pkg::coord_t'(1);
    y_walk     = y_neg_r ? cur_y_r - blw_pkg::coord_t'(1) : cur_y_r + blw_pkg::coord_t'(1);

    cur_x_nxt     = cur_x_r;
    cur_y_nxt     = cur_y_r;
    err_nxt       = err_r;
    inc_pos_nxt   = inc_pos_r;
    inc_neg_nxt   = inc_neg_r;
    steps_nxt     = steps_r;
    x_major_nxt   = x_major_r;
    x_neg_nxt     = x_neg_r;
    y_neg_nxt     = y_neg_r;
    out_valid_nxt = out_valid_r && !out_chan.ready;
    px_nxt        = px_r;
    py_nxt        = py_r;
    last_nxt      = last_r;

    if (cmd_pop) begin
      if (!cmd.is_step) begin
        cur_x_nxt   = cmd.x0;
        cur_y_nxt   = cmd.y0;
        err_nxt     = minor2_e - major_e;
        inc_pos_nxt = minor2_e;
        inc_neg_nxt = minor2_e - (major_e <<< 1);
        steps_nxt   = cmd.major;
        x_major_nxt = cmd.x_major;
        x_neg_nxt   = cmd.x_neg;
        y_neg_nxt   = cmd.y_neg;
      end else if (steps_r != '0) begin
        out_valid_nxt = 1'b1;
        px_nxt        = cur_x_r;
        py_nxt        = cur_y_r;
        last_nxt      = (steps_r == blw_pkg::coord_t'(1));
        steps_nxt     = steps_r - blw_pkg::coord_t'(1);
        err_nxt       = err_r + (step_minor ? inc_neg_r : inc_pos_r);
        if (x_major_r) begin
          cur_x_nxt = x_walk;
          if (step_minor) begin
            cur_y_nxt = y_walk;
          end
        end else begin
          cur_y_nxt = y_walk;
          if (step_minor) begin
            cur_x_nxt = x_walk;
          end
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cur_x_r     <= '0;
      cur_y_r     <= '0;
      err_r       <= '0;
      inc_pos_r   <= '0;
      inc_neg_r   <= '0;
      steps_r     <= '0;
      x_major_r   <= 1'b0;
      x_neg_r     <= 1'b0;
      y_neg_r     <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      cur_x_r     <= cur_x_nxt;
      cur_y_r     <= cur_y_nxt;
      err_r       <= err_nxt;
      inc_pos_r   <= inc_pos_nxt;
      inc_neg_r   <= inc_neg_nxt;
      steps_r     <= steps_nxt;
      x_major_r   <= x_major_nxt;
      x_neg_r     <= x_neg_nxt;
      y_neg_r     <= y_neg_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    px_r   <= px_nxt;
    py_r   <= py_nxt;
    last_r <= last_nxt;
  end

endmodule

### sv/bresenham_line_walker_unit.sv
// ----------------------------------------------------------------------------
// bresenham_line_walker_unit
// Integer Bresenham line rasterizer with a start/step command interface.
// ----------------------------------------------------------------------------
// A start beat (op 0) loads two endpoints and gives no pixel; each step beat
// (op 1) then gives the next pixel from the first endpoint toward the second,
// max(|dx|,|dy|) pixels in all, the second endpoint excluded, the final one
// flagged with last. A step with no line in progress gives nothing. The block
// takes one beat per clock and gives one pixel per clock while the output
// side does not stall: the classifier feeds a four-entry command queue, and
// the walker turns one queued command per cycle into a pixel in the output
// register (a start command gives none), so a step beat is first registered
// in the queue and then in the walker's output register. in_chan.ready drops
// only when the queue is full, which takes a stalled output side.
module bresenham_line_walker_unit (
  input  logic       clk,
  input  logic       rst_n,
  blw_in_if.sink     in_chan,
  blw_out_if.source  out_chan
);

  blw_pkg::cmd_t front_cmd;
  blw_pkg::cmd_t q_head;
  logic          q_full;
  logic          q_empty;
  logic          q_pop;

  assign in_chan.ready = !q_full;

  blw_front u_front (
    .op      (in_chan.op),
    .x_start (in_chan.x_start),
    .y_start (in_chan.y_start),
    .x_end   (in_chan.x_end),
    .y_end   (in_chan.y_end),
    .cmd     (front_cmd)
  );

  blw_fifo u_fifo (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (in_chan.valid),
    .push_data (front_cmd),
    .pop       (q_pop),
    .full      (q_full),
    .empty     (q_empty),
    .head      (q_head)
  );

  blw_back u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .cmd_valid (!q_empty),
    .cmd       (q_head),
    .cmd_pop   (q_pop),
    .out_chan  (out_chan)
  );

endmodule

### sv/blw_checker.sv
// ----------------------------------------------------------------------------
// blw_checker
// Port-level checks on the line walker, bound to the top level.
// ----------------------------------------------------------------------------
module blw_checker (
  input logic            clk,
  input logic            rst_n,
  input logic            in_valid,
  input logic            in_ready,
  input logic            in_op,
  input logic            out_valid,
  input logic            out_ready,
  input blw_pkg::coord_t out_px,
  input blw_pkg::coord_t out_py,
  input logic            out_last
);

  // step beats accepted minus pixel beats delivered
  logic [15:0] pend_r, pend_nxt;
  logic        step_acc;
  logic        out_acc;

  assign step_acc = in_valid && in_ready && (in_op == blw_pkg::OP_STEP);
  assign out_acc  = out_valid && out_ready;

  always_comb begin
    pend_nxt = pend_r;
    if (step_acc && !out_acc) begin
      pend_nxt = pend_r + 16'd1;
    end else if (out_acc && !step_acc) begin
      pend_nxt = pend_r - 16'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pend_r <= '0;
    end else begin
      pend_r <= pend_nxt;
    end
  end

  a_no_pixel_without_step: assert property (@(posedge clk) disable iff (!rst_n)
    out_acc |-> (pend_r != 16'd0))
    else $error("pixel beat without an outstanding step");

  a_idle_after_reset: assert property (@(posedge clk)
    $past(!rst_n) |-> !out_valid)
    else $error("output valid right after reset");

  a_valid_holds: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && !out_ready) |=> out_valid)
    else $error("output valid dropped while stalled");

  a_payload_holds: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && !out_ready) |=> ($stable(out_px) && $stable(out_py) && $stable(out_last)))
    else $error("output payload changed while stalled");

endmodule

bind bresenham_line_walker_unit blw_checker u_blw_checker (
  .clk       (clk),
  .rst_n     (rst_n),
  .in_valid  (in_chan.valid),
  .in_ready  (in_chan.ready),
  .in_op     (in_chan.op),
  .out_valid (out_chan.valid),
  .out_ready (out_chan.ready),
  .out_px    (out_chan.px),
  .out_py    (out_chan.py),
  .out_last  (out_chan.last)
);

### test/bresenham_line_walker_unit_test.sv
// ----------------------------------------------------------------------------
// bresenham_line_walker_unit_test
// Self-checking bench for the line walker: start and step beats go in over
// the valid/ready input channel, a line tracer in the bench predicts every
// pixel, and each pixel beat out is compared against the oldest prediction.
// Directed lines cover the corners and four octants, then random lines run under
// four idle/stall mixes with a full drain between them.
// ----------------------------------------------------------------------------
module bresenham_line_walker_unit_test;

  timeunit 1ns;
  timeprecision 1ps;

  localparam int WATCHDOG_LIMIT = 4000;
  localparam int TAIL_CYCLES    = 20;
  localparam int MAX_REPORTS    = 10;

  typedef struct {
    blw_pkg::coord_t px;
    blw_pkg::coord_t py;
    logic            last;
  } pixel_t;

  logic clk;
  logic rst_n;

  blw_in_if  in_chan ();
  blw_out_if out_chan ();

  bresenham_line_walker_unit u_dut (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_chan  (in_chan),
    .out_chan (out_chan)
  );

  // line tracer state
  blw_pkg::coord_t walk_x;
  blw_pkg::coord_t walk_y;
  int              walk_err;
  blw_pkg::coord_t walk_major;
  blw_pkg::coord_t walk_minor;
  blw_pkg::coord_t walk_left;
  logic            walk_x_major;
  logic            walk_x_neg;
  logic            walk_y_neg;

  pixel_t pending_pixels[$];
  int     mismatches    = 0;
  int     beats_done    = 0;
  int     send_idle_pct  = 0;
  int     recv_stall_pct = 0;
  int     stall_cycles   = 0;

  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  function automatic blw_pkg::coord_t step_coord(blw_pkg::coord_t pos, logic neg);
    return neg ? blw_pkg::coord_t'(pos - 1'b1) : blw_pkg::coord_t'(pos + 1'b1);
  endfunction

  // returns 1 when the beat did something (start, or a step that gave a pixel)
  function automatic bit trace_line_beat(logic op, blw_pkg::coord_t xs,
                                         blw_pkg::coord_t ys, blw_pkg::coord_t xe,
                                         blw_pkg::coord_t ye);
    blw_pkg::coord_t dx;
    blw_pkg::coord_t dy;
    pixel_t          pix;
    if (op == blw_pkg::OP_START) begin
      dx = (xe >= xs) ? blw_pkg::coord_t'(xe - xs) : blw_pkg::coord_t'(xs - xe);
      dy = (ye >= ys) ? blw_pkg::coord_t'(ye - ys) : blw_pkg::coord_t'(ys - ye);
      walk_x_neg   = xe < xs;
      walk_y_neg   = ye < ys;
      walk_x_major = dx > dy;
      walk_major   = walk_x_major ? dx : dy;
      walk_minor   = walk_x_major ? dy : dx;
      walk_err     = 2 * int'(walk_minor) - int'(walk_major);
      walk_left    = walk_major;
      walk_x       = xs;
      walk_y       = ys;
      return 1'b1;
    end
    if (walk_left == '0) return 1'b0;
    pix.px   = walk_x;
    pix.py   = walk_y;
    pix.last = (walk_left == blw_pkg::coord_t'(1));
    pending_pixels = {pending_pixels, pix};
    if (walk_err >= 0) begin
      if (walk_x_major) walk_y = step_coord(walk_y, walk_y_neg);
      else walk_x = step_coord(walk_x, walk_x_neg);
      walk_err += 2 * (int'(walk_minor) - int'(walk_major));
    end else begin
      walk_err += 2 * int'(walk_minor);
    end
    if (walk_x_major) walk_x = step_coord(walk_x, walk_x_neg);
    else walk_y = step_coord(walk_y, walk_y_neg);
    walk_left = blw_pkg::coord_t'(walk_left - 1'b1);
    return 1'b1;
  endfunction

  // entered and left at a falling edge
  task automatic send_beat(logic op, blw_pkg::coord_t xs, blw_pkg::coord_t ys,
                           blw_pkg::coord_t xe, blw_pkg::coord_t ye);
    while ($urandom_range(99) < send_idle_pct) begin
      in_chan.valid <= 1'b0;
      @(negedge clk);
    end
    in_chan.valid   <= 1'b1;
    in_chan.op      <= op;
    in_chan.x_start <= xs;
    in_chan.y_start <= ys;
    in_chan.x_end   <= xe;
    in_chan.y_end   <= ye;
    @(posedge clk);
    while (!in_chan.ready) @(posedge clk);
    if (trace_line_beat(op, xs, ys, xe, ye)) beats_done++;
    @(negedge clk);
  endtask

  task automatic send_step;
    send_beat(blw_pkg::OP_STEP,
              blw_pkg::coord_t'($urandom_range(4095)),
              blw_pkg::coord_t'($urandom_range(4095)),
              blw_pkg::coord_t'($urandom_range(4095)),
              blw_pkg::coord_t'($urandom_range(4095)));
  endtask

  task automatic wait_for_pixels;
    in_chan.valid <= 1'b0;
    while (pending_pixels.size() != 0) @(negedge clk);
  endtask

  function automatic void check_pixel(blw_pkg::coord_t px, blw_pkg::coord_t py,
                                      logic last);
    pixel_t want;
    if (pending_pixels.size() == 0) begin
      mismatches++;
      if (mismatches <= MAX_REPORTS)
        $display("unexpected pixel (%0d,%0d,last %0b)", px, py, last);
      return;
    end
    want = pending_pixels.pop_front();
    if (px !== want.px || py !== want.py || last !== want.last) begin
      mismatches++;
      if (mismatches <= MAX_REPORTS)
        $display("pixel mismatch: expected (%0d,%0d,last %0b) got (%0d,%0d,last %0b)",
                 want.px, want.py, want.last, px, py, last);
    end
  endfunction

  always @(posedge clk) begin
    if (rst_n && out_chan.valid && out_chan.ready)
      check_pixel(out_chan.px, out_chan.py, out_chan.last);
  end

  initial begin
    out_chan.ready = 1'b0;
    forever begin
      @(negedge clk);
      out_chan.ready <= ($urandom_range(99) >= recv_stall_pct);
    end
  end

  // counts cycles with no beat on either side
  initial begin
    while (stall_cycles < WATCHDOG_LIMIT) begin
      @(posedge clk);
      if ((in_chan.valid && in_chan.ready) || (out_chan.valid && out_chan.ready))
        stall_cycles = 0;
      else
        stall_cycles++;
    end
    $display("bresenham_line_walker_unit test failed");
    $finish;
  end

  task automatic test_idle_step;
    send_step();
  endtask

  task automatic test_zero_length;
    send_beat(blw_pkg::OP_START, 12'd4095, 12'd0, 12'd4095, 12'd0);
    send_step();
  endtask

  // full-range diagonals, abandoned after a couple of pixels
  task automatic test_extremes;
    send_beat(blw_pkg::OP_START, 12'd0, 12'd0, 12'd4095, 12'd4095);
    repeat (2) send_step();
    send_beat(blw_pkg::OP_START, 12'd4095, 12'd4095, 12'd0, 12'd0);
    repeat (2) send_step();
  endtask

  task automatic test_octants;
    // x major, walked past its end
    send_beat(blw_pkg::OP_START, 12'd100, 12'd200, 12'd103, 12'd201);
    repeat (4) send_step();
    // y major with x going down
    send_beat(blw_pkg::OP_START, 12'd50, 12'd60, 12'd49, 12'd63);
    repeat (3) send_step();
    // equal deltas, y major, y going down
    send_beat(blw_pkg::OP_START, 12'd10, 12'd10, 12'd13, 12'd7);
    repeat (3) send_step();
    // x major, both going down
    send_beat(blw_pkg::OP_START, 12'd2000, 12'd1000, 12'd1997, 12'd999);
    repeat (3) send_step();
    wait_for_pixels();
  endtask

  function automatic blw_pkg::coord_t near_point(blw_pkg::coord_t p, int span);
    int d;
    int q;
    d = int'($urandom_range(2 * span)) - span;
    q = int'(p) + d;
    if (q < 0 || q > 4095) q = int'(p) - d;
    return blw_pkg::coord_t'(q);
  endfunction

  task automatic send_random_line;
    int              pick;
    int              n;
    blw_pkg::coord_t xs;
    blw_pkg::coord_t ys;
    blw_pkg::coord_t xe;
    blw_pkg::coord_t ye;
    pick = $urandom_range(99);
    xs   = blw_pkg::coord_t'($urandom_range(4095));
    ys   = blw_pkg::coord_t'($urandom_range(4095));
    if (pick < 10) begin
      // noise: any op, any fields
      send_beat(($urandom_range(1) == 0) ? blw_pkg::OP_START : blw_pkg::OP_STEP, xs, ys,
                blw_pkg::coord_t'($urandom_range(4095)),
                blw_pkg::coord_t'($urandom_range(4095)));
      return;
    end
    if (pick < 14) begin
      // long line, cut short
      xe = blw_pkg::coord_t'($urandom_range(4095));
      ye = blw_pkg::coord_t'($urandom_range(4095));
    end else begin
      xe = near_point(xs, (pick < 60) ? 6 : 24);
      ye = near_point(ys, (pick < 60) ? 6 : 24);
    end
    send_beat(blw_pkg::OP_START, xs, ys, xe, ye);
    if (pick < 14) n = $urandom_range(40);
    else if ($urandom_range(9) < 7) n = int'(walk_left) + $urandom_range(2);
    else n = $urandom_range(int'(walk_left));
    repeat (n) send_step();
  endtask

  task automatic test_random_lines(int idle_pct, int stall_pct, int goal);
    int stop_at;
    send_idle_pct  = idle_pct;
    recv_stall_pct = stall_pct;
    stop_at        = beats_done + goal;
    while (beats_done < stop_at) send_random_line();
    // hold off until the walker has given everything back
    wait_for_pixels();
  endtask

  initial begin
    rst_n           = 1'b0;
    in_chan.valid   = 1'b0;
    in_chan.op      = blw_pkg::OP_START;
    in_chan.x_start = '0;
    in_chan.y_start = '0;
    in_chan.x_end   = '0;
    in_chan.y_end   = '0;
    repeat (11) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    test_idle_step();
    test_zero_length();
    test_extremes();
    test_octants();
    test_random_lines(0, 0, 340);
    test_random_lines(46, 0, 340);
    test_random_lines(0, 46, 340);
    test_random_lines(22, 22, 340);

    wait_for_pixels();
    repeat (TAIL_CYCLES) @(posedge clk);
    if (mismatches == 0 && pending_pixels.size() == 0) begin
      $display("bresenham_line_walker_unit test passed");
    end else begin
      $display("bresenham_line_walker_unit test failed");
    end
    $finish;
  end

endmodule
